FILE: rtl/core/ucd_pkg.sv
// Package for the undirected cycle detector.
// Holds the one-hot state encoding of the control sequencer.
// No dependencies.
package ucd_pkg;

    // The control sequencer uses one-hot state codes.
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_LDU   = 15'b000000000000010,
        S_LDUW  = 15'b000000000000100,
        S_LDV   = 15'b000000000001000,
        S_LDVW  = 15'b000000000010000,
        S_SCAN  = 15'b000000000100000,
        S_SCANW = 15'b000000001000000,
        S_DEQ   = 15'b000000010000000,
        S_DEQW  = 15'b000000100000000,
        S_CUR   = 15'b000001000000000,
        S_EDGE  = 15'b000010000000000,
        S_EDGEW = 15'b000100000000000,
        S_NB    = 15'b001000000000000,
        S_OUT   = 15'b010000000000000,
        S_CLR   = 15'b100000000000000
    } t_state;

    // Width of the node count register.
    localparam int NODE_COUNT_W = 9;

endpackage

FILE: rtl/core/undirected_cycle_detect_bfs.sv
// An accepted edge beat is stored through LDU, LDUW, LDV and LDVW, which link it into the
// lists of both endpoints; no new beat is accepted until that is done. A beat with no edge
// to store leaves the block ready for the next one. A last beat, after storing any edge,
// runs a breadth-first search over three memories, then presents one result beat.
// After each result, and after reset, a clearing pass over all MAX_NODES node entries
// resets list heads and visited marks; no input beat is accepted during it.
// Reset is synchronous and active low; node_count resets to zero.
// Top level of the undirected cycle detector; depends on ucd_pkg.
module undirected_cycle_detect_bfs import ucd_pkg::*; #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [NODE_COUNT_W-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_edge_u,
    input  logic [7:0]              i_edge_v,
    input  logic                    i_carries_edge,
    input  logic                    i_last_edge,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_cycle_found,
    output logic                    o_edge_overflow
);

    localparam int CAP = 2 * MAX_EDGES;
    localparam int EW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int HW  = $clog2(CAP + 1);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int PW  = NW + 1;
    localparam int LW  = (PW > NODE_COUNT_W) ? PW : NODE_COUNT_W;
    localparam int ENW = NW + HW;
    localparam int NDW = 1 + PW + HW;
    localparam logic [HW-1:0] NIL       = HW'(CAP);
    localparam logic [PW-1:0] NO_PARENT = PW'(MAX_NODES);

    // Control registers.
    t_state                  r_state, n_state;
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [NW-1:0]           r_u, r_v, r_cur, r_nb, r_clr;
    logic                    r_last, r_ovf, r_cycle;
    logic [HW-1:0]           r_cnt, r_e;
    logic [PW-1:0]           r_scan, r_qh, r_qt, r_pc;

    // Memories and their ports.
    logic [ENW-1:0] mem_ent [CAP];
    logic [NDW-1:0] mem_node [MAX_NODES];
    logic [NW-1:0]  mem_q [MAX_NODES];
    logic [ENW-1:0] ent_rdata, ent_wdata;
    logic [NDW-1:0] node_rdata, node_wdata;
    logic [NW-1:0]  q_rdata, q_wdata;
    logic [EW-1:0]  ent_raddr, ent_waddr;
    logic [NW-1:0]  node_raddr, node_waddr, q_raddr, q_waddr;
    logic           ent_we, node_we, q_we;

    // Fields of the words read back.
    logic          rd_vis;
    logic [PW-1:0] rd_par;
    logic [HW-1:0] rd_head;
    logic [NW-1:0] ent_nb;
    logic [HW-1:0] ent_next;

    logic          in_acc, out_acc, edge_ok, scan_more;
    logic [LW-1:0] limit;

    assign rd_vis   = node_rdata[NDW-1];
    assign rd_par   = node_rdata[HW +: PW];
    assign rd_head  = node_rdata[HW-1:0];
    assign ent_nb   = ent_rdata[HW +: NW];
    assign ent_next = ent_rdata[HW-1:0];

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_cycle_found   = r_cycle;
    assign o_edge_overflow = r_ovf;
    assign in_acc          = i_valid && o_ready;
    assign out_acc         = o_valid && i_ready;

    // An edge is stored only if both endpoints are in range and two entries remain.
    assign edge_ok = i_carries_edge && (32'(i_edge_u) < MAX_NODES)
                     && (32'(i_edge_v) < MAX_NODES)
                     && ((HW+1)'(r_cnt) + (HW+1)'(2) <= (HW+1)'(CAP));

    // Start nodes are scanned up to node_count, clipped to the node capacity.
    assign limit     = (LW'(r_node_count) > LW'(MAX_NODES)) ? LW'(MAX_NODES)
                                                            : LW'(r_node_count);
    assign scan_more = LW'(r_scan) < limit;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (edge_ok) n_state = S_LDU;
                    else if (i_last_edge) n_state = S_SCAN;
                end
            end
            S_LDU:   n_state = S_LDUW;
            S_LDUW:  n_state = S_LDV;
            S_LDV:   n_state = S_LDVW;
            S_LDVW:  n_state = r_last ? S_SCAN : S_IDLE;
            S_SCAN:  n_state = scan_more ? S_SCANW : S_OUT;
            S_SCANW: n_state = rd_vis ? S_SCAN : S_DEQ;
            S_DEQ:   n_state = (r_qh < r_qt) ? S_DEQW : S_SCAN;
            S_DEQW:  n_state = S_CUR;
            S_CUR:   n_state = S_EDGE;
            S_EDGE:  n_state = (r_e == NIL) ? S_DEQ : S_EDGEW;
            S_EDGEW: n_state = S_NB;
            S_NB: begin
                if (rd_vis && (r_pc != {1'b0, r_nb})) n_state = S_OUT;
                else n_state = S_EDGE;
            end
            S_OUT:   n_state = out_acc ? S_CLR : S_OUT;
            S_CLR:   n_state = (r_clr == NW'(MAX_NODES - 1)) ? S_IDLE : S_CLR;
            default: n_state = S_CLR;
        endcase
    end

    // Memory port controls.
    always_comb begin
        node_raddr = '0;
        node_waddr = '0;
        node_wdata = '0;
        node_we    = 1'b0;
        ent_raddr  = r_e[EW-1:0];
        ent_waddr  = '0;
        ent_wdata  = '0;
        ent_we     = 1'b0;
        q_raddr    = r_qh[NW-1:0];
        q_waddr    = '0;
        q_wdata    = '0;
        q_we       = 1'b0;
        unique case (r_state)
            S_LDU: node_raddr = r_u;
            S_LDUW: begin
                ent_we     = 1'b1;
                ent_waddr  = r_cnt[EW-1:0];
                ent_wdata  = {r_v, rd_head};
                node_we    = 1'b1;
                node_waddr = r_u;
                node_wdata = {rd_vis, rd_par, r_cnt};
            end
            S_LDV: node_raddr = r_v;
            S_LDVW: begin
                ent_we     = 1'b1;
                ent_waddr  = EW'(r_cnt + HW'(1));
                ent_wdata  = {r_u, rd_head};
                node_we    = 1'b1;
                node_waddr = r_v;
                node_wdata = {rd_vis, rd_par, HW'(r_cnt + HW'(1))};
            end
            S_SCAN: node_raddr = r_scan[NW-1:0];
            S_SCANW: begin
                if (!rd_vis) begin
                    node_we    = 1'b1;
                    node_waddr = r_scan[NW-1:0];
                    node_wdata = {1'b1, NO_PARENT, rd_head};
                    q_we       = 1'b1;
                    q_waddr    = '0;
                    q_wdata    = r_scan[NW-1:0];
                end
            end
            S_DEQW:  node_raddr = q_rdata;
            S_EDGEW: node_raddr = ent_nb;
            S_NB: begin
                if (!rd_vis) begin
                    node_we    = 1'b1;
                    node_waddr = r_nb;
                    node_wdata = {1'b1, {1'b0, r_cur}, rd_head};
                    if (32'(r_qt) < MAX_NODES) begin
                        q_we    = 1'b1;
                        q_waddr = r_qt[NW-1:0];
                        q_wdata = r_nb;
                    end
                end
            end
            S_CLR: begin
                node_we    = 1'b1;
                node_waddr = r_clr;
                node_wdata = {1'b0, {PW{1'b0}}, NIL};
            end
            default: begin
            end
        endcase
    end

    // Adjacency entry store: neighbor and next link.
    always_ff @(posedge i_clk) begin
        if (ent_we) mem_ent[ent_waddr] <= ent_wdata;
        ent_rdata <= mem_ent[ent_raddr];
    end

    // Per-node store: visited mark, parent and list head.
    always_ff @(posedge i_clk) begin
        if (node_we) mem_node[node_waddr] <= node_wdata;
        node_rdata <= mem_node[node_raddr];
    end

    // Search queue.
    always_ff @(posedge i_clk) begin
        if (q_we) mem_q[q_waddr] <= q_wdata;
        q_rdata <= mem_q[q_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_cycle      <= 1'b0;
            r_node_count <= '0;
            r_scan       <= '0;
            r_qh         <= '0;
            r_qt         <= '0;
            r_last       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_node_count <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_u     <= NW'(i_edge_u);
                        r_v     <= NW'(i_edge_v);
                        r_last  <= i_last_edge;
                        r_scan  <= '0;
                        r_cycle <= 1'b0;
                        if (i_carries_edge && !edge_ok) r_ovf <= 1'b1;
                    end
                end
                S_LDVW: r_cnt <= r_cnt + HW'(2);
                S_SCANW: begin
                    if (rd_vis) begin
                        r_scan <= r_scan + PW'(1);
                    end else begin
                        r_qh <= '0;
                        r_qt <= PW'(1);
                    end
                end
                S_DEQ: begin
                    if (r_qh < r_qt) r_qh <= r_qh + PW'(1);
                    else r_scan <= r_scan + PW'(1);
                end
                S_DEQW: r_cur <= q_rdata;
                S_CUR: begin
                    r_e  <= rd_head;
                    r_pc <= rd_par;
                end
                S_EDGEW: begin
                    r_nb <= ent_nb;
                    r_e  <= ent_next;
                end
                S_NB: begin
                    if (!rd_vis) begin
                        if (32'(r_qt) < MAX_NODES) r_qt <= r_qt + PW'(1);
                    end else if (r_pc != {1'b0, r_nb}) begin
                        r_cycle <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_clr <= '0;
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                    end
                end
                S_CLR: r_clr <= r_clr + NW'(1);
                default: begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The entry count never passes the store capacity.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CAP) else $error("entry count beyond capacity");

    // A taken result beat always starts a clearing pass.
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> (r_state == S_CLR)) else $error("no clear after result");

    // The queue read pointer never overtakes the write pointer while searching.
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ || r_state == S_DEQW) |-> (r_qh <= r_qt))
        else $error("queue pointers crossed");

    // An accepted edge beat that fits goes straight into the load sequence.
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && edge_ok) |=> (r_state == S_LDU))
        else $error("edge load not started");
`endif

endmodule

FILE: verif/ucd_checker.sv
// Checker for the undirected cycle detector: watches both channels, predicts
// each result with its own graph model and compares. Depends on ucd_pkg.
module ucd_checker import ucd_pkg::*; #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [NODE_COUNT_W-1:0] i_cfg_data,
    input  logic                    i_valid,
    input  logic                    i_ready_in,
    input  logic [7:0]              i_edge_u,
    input  logic [7:0]              i_edge_v,
    input  logic                    i_carries_edge,
    input  logic                    i_last_edge,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_cycle_found,
    input  logic                    i_edge_overflow,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results_seen,
    output int                      o_cycles_seen
);

    localparam int ENTRY_CAP = 2 * MAX_EDGES;

    typedef struct packed {
        logic cycle_found;
        logic edge_overflow;
    } t_verdict;

    // Model of the graph being loaded.
    int       nb_of_entry[ENTRY_CAP];
    int       next_of_entry[ENTRY_CAP];
    int       first_entry[MAX_NODES];
    bit       seen_node[MAX_NODES];
    int       came_from[MAX_NODES];
    int       walk_fifo[MAX_NODES];
    int       entries_used;
    bit       dropped_edge;
    logic [NODE_COUNT_W-1:0] scan_count;
    t_verdict verdicts_due[$];

    function automatic void wipe_graph();
        for (int i = 0; i < MAX_NODES; i++) begin
            first_entry[i] = ENTRY_CAP;
            seen_node[i] = 0;
        end
        entries_used = 0;
        dropped_edge = 0;
    endfunction

    function automatic void link(int from, int to);
        nb_of_entry[entries_used] = to;
        next_of_entry[entries_used] = first_entry[from];
        first_entry[from] = entries_used;
        entries_used++;
    endfunction

    // Breadth-first walk from one root; returns 1 when a back edge is met.
    function automatic bit walk_finds_loop(int root);
        int rd;
        int wr;
        int node;
        int e;
        int nb;
        rd = 0;
        wr = 0;
        walk_fifo[wr++] = root;
        seen_node[root] = 1;
        came_from[root] = MAX_NODES;
        while (rd < wr) begin
            node = walk_fifo[rd++];
            e = first_entry[node];
            while (e < ENTRY_CAP) begin
                nb = nb_of_entry[e];
                if (!seen_node[nb]) begin
                    came_from[nb] = node;
                    seen_node[nb] = 1;
                    if (wr < MAX_NODES) walk_fifo[wr++] = nb;
                end else if (came_from[node] != nb) begin
                    return 1;
                end
                e = next_of_entry[e];
            end
        end
        return 0;
    endfunction

    function automatic void absorb_beat(logic [7:0] u, logic [7:0] v, logic has_edge,
                                        logic is_last);
        t_verdict vd;
        int lim;
        bit loop_seen;
        if (has_edge) begin
            if (u >= MAX_NODES || v >= MAX_NODES || entries_used + 2 > ENTRY_CAP) begin
                dropped_edge = 1;
            end else begin
                link(u, v);
                link(v, u);
            end
        end
        if (!is_last) return;
        lim = (scan_count > MAX_NODES) ? MAX_NODES : scan_count;
        loop_seen = 0;
        for (int s = 0; s < lim && !loop_seen; s++) begin
            if (!seen_node[s]) loop_seen = walk_finds_loop(s);
        end
        vd.cycle_found = loop_seen;
        vd.edge_overflow = dropped_edge;
        verdicts_due = {verdicts_due, vd};
        wipe_graph();
    endfunction

    // Sample both channels at each rising edge.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            wipe_graph();
            scan_count <= '0;
            verdicts_due.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_cycles_seen <= 0;
        end else begin
            if (i_cfg_we) scan_count <= i_cfg_data;
            if (i_valid && i_ready_in)
                absorb_beat(i_edge_u, i_edge_v, i_carries_edge, i_last_edge);
            if (i_out_valid && i_out_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (i_cycle_found) o_cycles_seen <= o_cycles_seen + 1;
                if (verdicts_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat: cycle=%0b overflow=%0b",
                                 i_cycle_found, i_edge_overflow);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.cycle_found !== i_cycle_found ||
                        want.edge_overflow !== i_edge_overflow) begin
                        if (o_fail_count < 10)
                            $display("result %0d: expected cycle=%0b overflow=%0b, got %0b %0b",
                                     o_results_seen, want.cycle_found, want.edge_overflow,
                                     i_cycle_found, i_edge_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = verdicts_due.size();

endmodule

FILE: verif/tb.sv
// Testbench top for the undirected cycle detector: makes edge stimulus and
// gives the verdict. Depends on ucd_pkg, the block and ucd_checker.
module tb;
    import ucd_pkg::*;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [NODE_COUNT_W-1:0] i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic [7:0]              i_edge_u;
    logic [7:0]              i_edge_v;
    logic                    i_carries_edge;
    logic                    i_last_edge;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_cycle_found;
    logic                    o_edge_overflow;
    int                      fail_count;
    int                      pending;
    int                      results_seen;
    int                      cycles_seen;
    int                      beats_sent;
    bit                      calm_phase;

    undirected_cycle_detect_bfs #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_edge_u(i_edge_u), .i_edge_v(i_edge_v),
        .i_carries_edge(i_carries_edge), .i_last_edge(i_last_edge), .o_valid(o_valid),
        .i_ready(i_ready), .o_cycle_found(o_cycle_found), .o_edge_overflow(o_edge_overflow)
    );

    ucd_checker #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_edge_u(i_edge_u),
        .i_edge_v(i_edge_v), .i_carries_edge(i_carries_edge), .i_last_edge(i_last_edge),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_cycle_found(o_cycle_found),
        .i_edge_overflow(o_edge_overflow), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_cycles_seen(cycles_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side stalls about 11 percent of cycles, except in the calm phase.
    always @(posedge i_clk) begin
        i_ready <= calm_phase || ($urandom_range(99) >= 11);
    end

    // Present one beat, with random idle cycles first, and wait for acceptance.
    // Valid stays up after acceptance; the next beat or a drain replaces it
    // in the same time step.
    task automatic send_beat(logic [7:0] u, logic [7:0] v, logic has_edge, logic is_last);
        if (!calm_phase && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (!calm_phase && $urandom_range(99) < 11) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_edge_u <= u;
        i_edge_v <= v;
        i_carries_edge <= has_edge;
        i_last_edge <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Wait until all results are back, then past the clearing pass.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (MAX_NODES + 20) @(posedge i_clk);
    endtask

    task automatic set_node_count(int n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= n[NODE_COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random graph over nodes below span; mostly trees, sometimes a loop.
    task automatic send_graph(int span, int edges);
        int a;
        int b;
        for (int k = 0; k < edges; k++) begin
            b = k + 1;
            if (b >= span) b = int'($urandom_range(span - 1));
            a = (b > 0 && $urandom_range(3) != 0) ? int'($urandom_range(b - 1))
                                                  : int'($urandom_range(span - 1));
            if ($urandom_range(1)) send_beat(8'(a), 8'(b), 1'b1, 1'b0);
            else send_beat(8'(b), 8'(a), 1'b1, 1'b0);
            if ($urandom_range(15) == 0) send_beat(8'($urandom), 8'($urandom), 1'b0, 1'b0);
        end
        if ($urandom_range(1)) send_beat(8'($urandom), 8'($urandom), 1'b0, 1'b1);
        else send_beat(8'($urandom_range(span - 1)), 8'($urandom_range(span - 1)),
                       1'b1, 1'b1);
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_edge_u = '0;
        i_edge_v = '0;
        i_carries_edge = 1'b0;
        i_last_edge = 1'b0;
        i_ready = 1'b0;
        calm_phase = 0;
        beats_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (MAX_NODES + 20) @(posedge i_clk);

        // Directed: empty graph at node count zero, then self-loop, parallel edge,
        // triangle, a tree, extreme ids.
        send_beat(8'h00, 8'h00, 1'b0, 1'b1);
        set_node_count(256);
        send_beat(8'h05, 8'h05, 1'b1, 1'b1);
        send_beat(8'h01, 8'h02, 1'b1, 1'b0);
        send_beat(8'h02, 8'h01, 1'b1, 1'b1);
        send_beat(8'h00, 8'h01, 1'b1, 1'b0);
        send_beat(8'h01, 8'h02, 1'b1, 1'b0);
        send_beat(8'h33, 8'h44, 1'b0, 1'b0);
        send_beat(8'h02, 8'h00, 1'b1, 1'b1);
        send_beat(8'h00, 8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 8'hAA, 1'b1, 1'b1);
        send_beat(8'hFF, 8'hFF, 1'b1, 1'b1);
        set_node_count(511);
        send_beat(8'hFF, 8'hFF, 1'b1, 1'b1);
        // Loop among high nodes, scanned only when node count covers them.
        set_node_count(3);
        send_beat(8'hF0, 8'hF1, 1'b1, 1'b0);
        send_beat(8'hF1, 8'hF2, 1'b1, 1'b0);
        send_beat(8'hF2, 8'hF0, 1'b1, 1'b1);
        set_node_count(0);
        send_beat(8'h00, 8'h00, 1'b1, 1'b1);

        // Random graphs under several node count settings.
        while (beats_sent < 800) begin
            drain();
            case ($urandom_range(4))
                0: n = 0;
                1: n = 256;
                2: n = 511;
                default: n = int'($urandom_range(1, 300));
            endcase
            set_node_count(n);
            calm_phase = ($urandom_range(5) == 0);
            repeat ($urandom_range(2, 5))
                send_graph($urandom_range(0, 7) == 0 ? 256 : int'($urandom_range(2, 24)),
                           int'($urandom_range(1, 20)));
            calm_phase = 0;
        end

        drain();
        $display("Ran %0d input beats; %0d results checked, %0d of them with a cycle.",
                 beats_sent, results_seen, cycles_seen);
        if (fail_count == 0) begin
            $display("undirected_cycle_detect_bfs: match");
        end else begin
            $display("undirected_cycle_detect_bfs: mismatch");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("undirected_cycle_detect_bfs: mismatch");
        $finish;
    end

endmodule

FILE: undirected_cycle_detect_bfs.f
rtl/core/ucd_pkg.sv
rtl/core/undirected_cycle_detect_bfs.sv
verif/ucd_checker.sv
verif/tb.sv
